[hw/rtl/psx_pkg.sv]
// ----------------------------------------------------------------------------
// psx_pkg: shared types and constants of the page statistics block
// Table size, slot widths, page code values, the per-slot statistics record
// and the field codes that step the shared adder through that record.
// ----------------------------------------------------------------------------
`default_nettype none

package psx_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int KEY_W         = 64;
   localparam int SUM_W         = 48;

   localparam logic [15:0] LEVEL_LEAF = 16'd0;
   localparam logic [15:0] LEVEL_ROOT = 16'd1;
   localparam logic [15:0] DIR_LEFT   = 16'd1;
   localparam logic [15:0] DIR_RIGHT  = 16'd2;
   localparam logic [15:0] DIR_NONE   = 16'd5;

   typedef struct packed {
      logic [31:0]      root;
      logic [31:0]      leaf;
      logic [31:0]      total;
      logic [SUM_W-1:0] garbage;
      logic [31:0]      left;
      logic [31:0]      right;
      logic [31:0]      none;
      logic [31:0]      mismatch;
   } stat_type;

   localparam int STAT_W = $bits(stat_type);

   typedef struct packed {
      logic [31:0]      page_number;
      logic [KEY_W-1:0] index_key;
      logic [15:0]      tree_level;
      logic [15:0]      garbage_bytes;
      logic [15:0]      insert_direction;
      logic [31:0]      header_lsn_low;
      logic [31:0]      trailer_lsn_low;
   } item_type;

   typedef enum logic [2:0] {
      FLD_ROOT     = 3'd0,
      FLD_LEAF     = 3'd1,
      FLD_TOTAL    = 3'd2,
      FLD_GARBAGE  = 3'd3,
      FLD_LEFT     = 3'd4,
      FLD_RIGHT    = 3'd5,
      FLD_NONE     = 3'd6,
      FLD_MISMATCH = 3'd7
   } fld_type;

   typedef struct packed {
      logic    load;
      logic    clear;
      logic    step;
      fld_type fld;
   } alu_ctl_type;

endpackage

`default_nettype wire

[hw/rtl/psx_ram.sv]
// ----------------------------------------------------------------------------
// psx_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module psx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[hw/rtl/psx_stat_alu.sv]
// ----------------------------------------------------------------------------
// psx_stat_alu: shared statistics adder
// Holds the record of the current slot and updates one field per step through
// a single 48-bit adder.
// ----------------------------------------------------------------------------
`default_nettype none

module psx_stat_alu
   import psx_pkg::*;
(
   input  wire logic        clock,
   input  wire alu_ctl_type ctl,
   input  wire item_type    item,
   input  wire stat_type    rd_data,
   output stat_type         record
);

   stat_type         record_ff;
   stat_type         record_in;
   logic [SUM_W-1:0] operand;
   logic [SUM_W-1:0] addend;
   logic [SUM_W-1:0] sum;

   always_comb begin
      operand = '0;
      addend  = '0;
      unique case (ctl.fld)
         FLD_ROOT: begin
            operand = SUM_W'(record_ff.root);
         end
         FLD_LEAF: begin
            operand = SUM_W'(record_ff.leaf);
            addend  = SUM_W'(item.tree_level == LEVEL_LEAF);
         end
         FLD_TOTAL: begin
            operand = SUM_W'(record_ff.total);
            addend  = SUM_W'(1'b1);
         end
         FLD_GARBAGE: begin
            operand = record_ff.garbage;
            addend  = SUM_W'(item.garbage_bytes);
         end
         FLD_LEFT: begin
            operand = SUM_W'(record_ff.left);
            addend  = SUM_W'(item.insert_direction == DIR_LEFT);
         end
         FLD_RIGHT: begin
            operand = SUM_W'(record_ff.right);
            addend  = SUM_W'(item.insert_direction == DIR_RIGHT);
         end
         FLD_NONE: begin
            operand = SUM_W'(record_ff.none);
            addend  = SUM_W'(item.insert_direction == DIR_NONE);
         end
         FLD_MISMATCH: begin
            operand = SUM_W'(record_ff.mismatch);
            addend  = SUM_W'(item.header_lsn_low != item.trailer_lsn_low);
         end
         default: begin
            operand = '0;
         end
      endcase
   end

   assign sum = operand + addend;

   always_comb begin
      record_in = record_ff;
      if (ctl.load) begin
         record_in = ctl.clear ? '0 : rd_data;
      end else if (ctl.step) begin
         unique case (ctl.fld)
            FLD_ROOT: begin
               if (item.tree_level == LEVEL_ROOT) begin
                  record_in.root = item.page_number;
               end
            end
            FLD_LEAF:     record_in.leaf     = sum[31:0];
            FLD_TOTAL:    record_in.total    = sum[31:0];
            FLD_GARBAGE:  record_in.garbage  = sum;
            FLD_LEFT:     record_in.left     = sum[31:0];
            FLD_RIGHT:    record_in.right    = sum[31:0];
            FLD_NONE:     record_in.none     = sum[31:0];
            FLD_MISMATCH: record_in.mismatch = sum[31:0];
            default:      record_in = record_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      record_ff <= record_in;
   end

   assign record = record_ff;

endmodule

`default_nettype wire

[hw/rtl/per_index_page_statistics.sv]
// ----------------------------------------------------------------------------
// per_index_page_statistics: per-index page statistics table
// Files each page header under its index id in a keyed table, allocating the
// lowest free slot for a new id, and returns the updated slot statistics.
// ----------------------------------------------------------------------------
//  channel   ports                   handshake
//  request   start, busy, req_*      taken when start=1 and busy=0
//  response  rsp_valid, rsp_*        one-cycle strobe, cannot be held off
//
//  The response strobe rises after a key scan of one slot per cycle through
//  the key RAM read port, then a fetch of the slot record and eight steps of
//  the shared statistics adder. A full-table item answers right after the scan.
//  busy is high for the whole item. Reset empties the table at once.
// ----------------------------------------------------------------------------
`default_nettype none

module per_index_page_statistics
   import psx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_page_number,
   input  wire logic [63:0] req_index_key,
   input  wire logic [15:0] req_tree_level,
   input  wire logic [15:0] req_garbage_bytes,
   input  wire logic [15:0] req_insert_direction,
   input  wire logic [31:0] req_header_lsn_low,
   input  wire logic [31:0] req_trailer_lsn_low,
   output logic             rsp_valid,
   output logic [4:0]       rsp_slot_index,
   output logic             rsp_is_new_entry,
   output logic             rsp_table_full,
   output logic [31:0]      rsp_root_page_number,
   output logic [31:0]      rsp_leaf_page_count,
   output logic [31:0]      rsp_page_count,
   output logic [47:0]      rsp_garbage_sum,
   output logic [31:0]      rsp_left_count,
   output logic [31:0]      rsp_right_count,
   output logic [31:0]      rsp_none_count,
   output logic [31:0]      rsp_lsn_mismatch_count
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_FETCH,
      ST_LOAD,
      ST_UPDATE,
      ST_DONE
   } state_type;

   state_type          state_ff;
   item_type           item_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [CNT_W-1:0]   issue_cnt_ff;
   logic               cmp_vld_ff;
   logic [SLOT_W-1:0]  cmp_idx_ff;
   logic               found_ff;
   logic               have_free_ff;
   logic [SLOT_W-1:0]  free_ff;
   logic [SLOT_W-1:0]  hit_ff;
   logic               new_ff;
   fld_type            fld_ff;

   logic               issuing;
   logic               key_wr_en;
   logic [KEY_W-1:0]   key_rd_data;
   logic               stat_wr_en;
   stat_type           stat_rd_data;
   stat_type           record;
   alu_ctl_type        alu_ctl;

   assign busy    = (state_ff != ST_IDLE);
   assign issuing = (state_ff == ST_SCAN) && (issue_cnt_ff < CNT_W'(TABLE_ENTRIES));

   assign key_wr_en  = (state_ff == ST_DECIDE) && !found_ff && have_free_ff;
   assign stat_wr_en = (state_ff == ST_DONE);

   assign alu_ctl.load  = (state_ff == ST_LOAD);
   assign alu_ctl.clear = new_ff;
   assign alu_ctl.step  = (state_ff == ST_UPDATE);
   assign alu_ctl.fld   = fld_ff;

   psx_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (free_ff),
      .wr_data (item_ff.index_key),
      .rd_addr (issue_cnt_ff[SLOT_W-1:0]),
      .rd_data (key_rd_data)
   );

   psx_ram #(
      .WIDTH (STAT_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_stat_ram (
      .clock   (clock),
      .wr_en   (stat_wr_en),
      .wr_addr (hit_ff),
      .wr_data (record),
      .rd_addr (hit_ff),
      .rd_data (stat_rd_data)
   );

   psx_stat_alu u_alu (
      .clock   (clock),
      .ctl     (alu_ctl),
      .item    (item_ff),
      .rd_data (stat_rd_data),
      .record  (record)
   );

   always_ff @(posedge clock) begin
      rsp_valid <= 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_ff.page_number      <= req_page_number;
               item_ff.index_key        <= req_index_key;
               item_ff.tree_level       <= req_tree_level;
               item_ff.garbage_bytes    <= req_garbage_bytes;
               item_ff.insert_direction <= req_insert_direction;
               item_ff.header_lsn_low   <= req_header_lsn_low;
               item_ff.trailer_lsn_low  <= req_trailer_lsn_low;
               issue_cnt_ff <= '0;
               cmp_vld_ff   <= 1'b0;
               found_ff     <= 1'b0;
               have_free_ff <= 1'b0;
               state_ff     <= ST_SCAN;
            end
         end
         ST_SCAN: begin
            // address goes out one cycle, compare lands the next
            if (issuing) begin
               issue_cnt_ff <= issue_cnt_ff + CNT_W'(1);
            end
            cmp_vld_ff <= issuing;
            cmp_idx_ff <= issue_cnt_ff[SLOT_W-1:0];
            if (cmp_vld_ff) begin
               if (valid_ff[cmp_idx_ff]) begin
                  if (!found_ff && key_rd_data == item_ff.index_key) begin
                     found_ff <= 1'b1;
                     hit_ff   <= cmp_idx_ff;
                  end
               end else if (!have_free_ff) begin
                  have_free_ff <= 1'b1;
                  free_ff      <= cmp_idx_ff;
               end
               if (cmp_idx_ff == SLOT_W'(TABLE_ENTRIES - 1)) begin
                  state_ff <= ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            new_ff <= 1'b0;
            if (found_ff) begin
               state_ff <= ST_FETCH;
            end else if (have_free_ff) begin
               // claim the lowest free slot; its record starts from zero
               valid_ff[free_ff] <= 1'b1;
               hit_ff            <= free_ff;
               new_ff            <= 1'b1;
               state_ff          <= ST_FETCH;
            end else begin
               // drop the item and report the full table
               rsp_valid              <= 1'b1;
               rsp_slot_index         <= '0;
               rsp_is_new_entry       <= 1'b0;
               rsp_table_full         <= 1'b1;
               rsp_root_page_number   <= '0;
               rsp_leaf_page_count    <= '0;
               rsp_page_count         <= '0;
               rsp_garbage_sum        <= '0;
               rsp_left_count         <= '0;
               rsp_right_count        <= '0;
               rsp_none_count         <= '0;
               rsp_lsn_mismatch_count <= '0;
               state_ff               <= ST_IDLE;
            end
         end
         ST_FETCH: begin
            state_ff <= ST_LOAD;
         end
         ST_LOAD: begin
            fld_ff   <= FLD_ROOT;
            state_ff <= ST_UPDATE;
         end
         ST_UPDATE: begin
            fld_ff <= fld_type'(fld_ff + 3'd1);
            if (fld_ff == FLD_MISMATCH) begin
               state_ff <= ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid              <= 1'b1;
            rsp_slot_index         <= 5'(hit_ff);
            rsp_is_new_entry       <= new_ff;
            rsp_table_full         <= 1'b0;
            rsp_root_page_number   <= record.root;
            rsp_leaf_page_count    <= record.leaf;
            rsp_page_count         <= record.total;
            rsp_garbage_sum        <= record.garbage;
            rsp_left_count         <= record.left;
            rsp_right_count        <= record.right;
            rsp_none_count         <= record.none;
            rsp_lsn_mismatch_count <= record.mismatch;
            state_ff               <= ST_IDLE;
         end
         default: begin
            state_ff <= ST_IDLE;
         end
      endcase
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= '0;
         rsp_valid <= 1'b0;
      end
   end

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for per_index_page_statistics
// Drives directed page headers, then random bursts, over the start/busy port.
// A small table predictor files each accepted header under its index id and
// queues the expected slot statistics. Every response strobe is checked field
// by field against the oldest queued result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import psx_pkg::*;

   localparam int RANDOM_PAGES = 1700;
   localparam int DRAIN_CYCLES = 80;

   localparam logic [63:0] KEY_ZERO  = 64'h0000_0000_0000_0000;
   localparam logic [63:0] KEY_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] KEY_TOP   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] KEY_UNIT  = 64'h0000_0000_0000_0001;
   localparam logic [63:0] KEY_CHECK = 64'h5555_5555_AAAA_AAAA;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              fresh;
      logic              full;
      stat_type          stats;
   } page_result_type;

   class index_stats_board;
      bit              used  [TABLE_ENTRIES];
      logic [63:0]     keys  [TABLE_ENTRIES];
      stat_type        stats [TABLE_ENTRIES];
      page_result_type due_results[$];
      int              faults;
      int              shown;

      function new();
         for (int s = 0; s < TABLE_ENTRIES; s++) begin
            used[s]  = 1'b0;
            keys[s]  = '0;
            stats[s] = '0;
         end
         faults = 0;
         shown  = 0;
      endfunction

      // Look up or allocate the slot of an accepted page and queue its result.
      function void file_page(item_type pg);
         int              hit;
         int              vacant;
         bit              found;
         page_result_type res;
         hit    = 0;
         vacant = -1;
         found  = 1'b0;
         res    = '0;
         for (int s = 0; s < TABLE_ENTRIES; s++) begin
            if (used[s]) begin
               if (!found && keys[s] == pg.index_key) begin
                  found = 1'b1;
                  hit   = s;
               end
            end else if (vacant < 0) begin
               vacant = s;
            end
         end
         if (!found && vacant < 0) begin
            // drop the page, state untouched
            res.full = 1'b1;
            due_results.push_back(res);
            return;
         end
         if (!found) begin
            hit       = vacant;
            used[hit] = 1'b1;
            keys[hit] = pg.index_key;
            stats[hit] = '0;
            res.fresh = 1'b1;
         end
         if (pg.tree_level == LEVEL_ROOT)
            stats[hit].root = pg.page_number;
         else if (pg.tree_level == LEVEL_LEAF)
            stats[hit].leaf = stats[hit].leaf + 32'd1;
         stats[hit].total   = stats[hit].total + 32'd1;
         stats[hit].garbage = stats[hit].garbage + {32'd0, pg.garbage_bytes};
         if (pg.insert_direction == DIR_LEFT)
            stats[hit].left = stats[hit].left + 32'd1;
         else if (pg.insert_direction == DIR_RIGHT)
            stats[hit].right = stats[hit].right + 32'd1;
         else if (pg.insert_direction == DIR_NONE)
            stats[hit].none = stats[hit].none + 32'd1;
         if (pg.header_lsn_low != pg.trailer_lsn_low)
            stats[hit].mismatch = stats[hit].mismatch + 32'd1;
         res.slot  = hit[SLOT_W-1:0];
         res.stats = stats[hit];
         due_results.push_back(res);
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            faults++;
            if (shown < 10)
               $display("mismatch on %s: expected %h, got %h", field, want, got);
            shown++;
         end
      endfunction

      function void match_result(page_result_type got);
         page_result_type want;
         if (due_results.size() == 0) begin
            faults++;
            if (shown < 10)
               $display("unexpected response: slot %0d", got.slot);
            shown++;
            return;
         end
         want = due_results.pop_front();
         compare_field("slot_index", 64'(want.slot), 64'(got.slot));
         compare_field("is_new_entry", 64'(want.fresh), 64'(got.fresh));
         compare_field("table_full", 64'(want.full), 64'(got.full));
         compare_field("root_page_number", 64'(want.stats.root), 64'(got.stats.root));
         compare_field("leaf_page_count", 64'(want.stats.leaf), 64'(got.stats.leaf));
         compare_field("page_count", 64'(want.stats.total), 64'(got.stats.total));
         compare_field("garbage_sum", 64'(want.stats.garbage), 64'(got.stats.garbage));
         compare_field("left_count", 64'(want.stats.left), 64'(got.stats.left));
         compare_field("right_count", 64'(want.stats.right), 64'(got.stats.right));
         compare_field("none_count", 64'(want.stats.none), 64'(got.stats.none));
         compare_field("lsn_mismatch_count", 64'(want.stats.mismatch),
                       64'(got.stats.mismatch));
      endfunction

      function int outstanding();
         return due_results.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_page_number;
   logic [63:0] req_index_key;
   logic [15:0] req_tree_level;
   logic [15:0] req_garbage_bytes;
   logic [15:0] req_insert_direction;
   logic [31:0] req_header_lsn_low;
   logic [31:0] req_trailer_lsn_low;
   logic        rsp_valid;
   logic [4:0]  rsp_slot_index;
   logic        rsp_is_new_entry;
   logic        rsp_table_full;
   logic [31:0] rsp_root_page_number;
   logic [31:0] rsp_leaf_page_count;
   logic [31:0] rsp_page_count;
   logic [47:0] rsp_garbage_sum;
   logic [31:0] rsp_left_count;
   logic [31:0] rsp_right_count;
   logic [31:0] rsp_none_count;
   logic [31:0] rsp_lsn_mismatch_count;

   index_stats_board board;
   logic [63:0]      key_pool[$];

   per_index_page_statistics u_top (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_page_number        (req_page_number),
      .req_index_key          (req_index_key),
      .req_tree_level         (req_tree_level),
      .req_garbage_bytes      (req_garbage_bytes),
      .req_insert_direction   (req_insert_direction),
      .req_header_lsn_low     (req_header_lsn_low),
      .req_trailer_lsn_low    (req_trailer_lsn_low),
      .rsp_valid              (rsp_valid),
      .rsp_slot_index         (rsp_slot_index),
      .rsp_is_new_entry       (rsp_is_new_entry),
      .rsp_table_full         (rsp_table_full),
      .rsp_root_page_number   (rsp_root_page_number),
      .rsp_leaf_page_count    (rsp_leaf_page_count),
      .rsp_page_count         (rsp_page_count),
      .rsp_garbage_sum        (rsp_garbage_sum),
      .rsp_left_count         (rsp_left_count),
      .rsp_right_count        (rsp_right_count),
      .rsp_none_count         (rsp_none_count),
      .rsp_lsn_mismatch_count (rsp_lsn_mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Present one page header at a falling edge and hold it until taken.
   // Leaves start high so a following item can go out back to back.
   task automatic send_page(input logic [31:0] page, input logic [63:0] key,
                            input logic [15:0] level, input logic [15:0] garbage,
                            input logic [15:0] dir, input logic [31:0] hlsn,
                            input logic [31:0] tlsn);
      item_type pg;
      pg.page_number      = page;
      pg.index_key        = key;
      pg.tree_level       = level;
      pg.garbage_bytes    = garbage;
      pg.insert_direction = dir;
      pg.header_lsn_low   = hlsn;
      pg.trailer_lsn_low  = tlsn;
      req_page_number      = page;
      req_index_key        = key;
      req_tree_level       = level;
      req_garbage_bytes    = garbage;
      req_insert_direction = dir;
      req_header_lsn_low   = hlsn;
      req_trailer_lsn_low  = tlsn;
      start                = 1'b1;
      do @(posedge clock); while (busy);
      board.file_page(pg);
      @(negedge clock);
   endtask

   // Mostly known ids so entries build up; new ids fill the table, and once
   // it is full the odd one-off id exercises the drop path.
   task automatic send_random_page();
      logic [63:0] key;
      logic [15:0] level;
      logic [15:0] dir;
      logic [15:0] garbage;
      logic [31:0] hlsn;
      logic [31:0] tlsn;
      int          pick;
      pick = $urandom_range(0, 99);
      if (key_pool.size() < TABLE_ENTRIES && pick < 10) begin
         key = {$urandom, $urandom};
         key_pool.push_back(key);
      end else if (key_pool.size() >= TABLE_ENTRIES && pick < 7) begin
         key = {$urandom, $urandom};
      end else begin
         key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end
      pick = $urandom_range(0, 99);
      if (pick < 40)      level = LEVEL_LEAF;
      else if (pick < 65) level = LEVEL_ROOT;
      else if (pick < 70) level = 16'hFFFF;
      else                level = 16'($urandom_range(2, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 28)      dir = DIR_LEFT;
      else if (pick < 56) dir = DIR_RIGHT;
      else if (pick < 84) dir = DIR_NONE;
      else                dir = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 10)      garbage = 16'h0000;
      else if (pick < 20) garbage = 16'hFFFF;
      else                garbage = 16'($urandom);
      hlsn = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 50)      tlsn = hlsn;
      else if (pick < 60) tlsn = hlsn ^ (32'd1 << $urandom_range(0, 31));
      else                tlsn = $urandom;
      send_page($urandom, key, level, garbage, dir, hlsn, tlsn);
   endtask

   always @(posedge clock) begin
      page_result_type got;
      got = {rsp_slot_index, rsp_is_new_entry, rsp_table_full, rsp_root_page_number,
             rsp_leaf_page_count, rsp_page_count, rsp_garbage_sum, rsp_left_count,
             rsp_right_count, rsp_none_count, rsp_lsn_mismatch_count};
      if (!reset && rsp_valid)
         board.match_result(got);
   end

   initial begin
      int burst;
      int drain;
      board                = new();
      reset                = 1'b1;
      start                = 1'b0;
      req_page_number      = '0;
      req_index_key        = '0;
      req_tree_level       = '0;
      req_garbage_bytes    = '0;
      req_insert_direction = '0;
      req_header_lsn_low   = '0;
      req_trailer_lsn_low  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes, every level and direction case, repeats on one id
      send_page(32'h0000_0000, KEY_ZERO, LEVEL_LEAF, 16'h0000, DIR_LEFT,
                32'h0000_0000, 32'h0000_0000);
      send_page(32'hFFFF_FFFF, KEY_ONES, LEVEL_ROOT, 16'hFFFF, DIR_RIGHT,
                32'h0000_0000, 32'hFFFF_FFFF);
      send_page(32'h1234_5678, KEY_ZERO, LEVEL_ROOT, 16'hFFFF, DIR_NONE,
                32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_page(32'h0000_0000, KEY_ONES, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_page(32'h0000_0001, KEY_ZERO, 16'd2, 16'h0001, 16'd0,
                32'h8000_0000, 32'h0000_0000);
      start = 1'b0;
      repeat (17) @(negedge clock);
      send_page(32'h0000_0002, KEY_ZERO, 16'd3, 16'h8000, 16'd3,
                32'h0000_0001, 32'h0000_0001);
      send_page(32'h8000_0000, KEY_TOP, LEVEL_LEAF, 16'h7FFF, 16'd4,
                32'hAAAA_AAAA, 32'h5555_5555);
      send_page(32'h7FFF_FFFF, KEY_UNIT, LEVEL_ROOT, 16'h0000, 16'd6,
                32'h5555_5555, 32'h5555_5555);
      send_page(32'hFFFF_FFFF, KEY_TOP, LEVEL_ROOT, 16'hFFFF, DIR_LEFT,
                32'h0000_0000, 32'h0000_0001);
      repeat (6) begin
         send_page(32'hDEAD_BEEF, KEY_ONES, LEVEL_LEAF, 16'hFFFF, DIR_NONE,
                   32'h0F0F_0F0F, 32'hF0F0_F0F0);
      end
      send_page(32'h0000_FFFF, KEY_CHECK, LEVEL_LEAF, 16'h00FF, DIR_NONE,
                32'h1111_1111, 32'h1111_1111);
      send_page(32'hFFFF_0000, KEY_UNIT, 16'h8000, 16'hFF00, 16'h8000,
                32'hFFFF_0000, 32'h0000_FFFF);
      send_page(32'h0F0F_0F0F, KEY_CHECK, LEVEL_ROOT, 16'h0000, DIR_RIGHT,
                32'h0000_0000, 32'h0000_0000);

      key_pool = '{KEY_ZERO, KEY_ONES, KEY_TOP, KEY_UNIT, KEY_CHECK};
      burst    = 0;
      repeat (RANDOM_PAGES) begin
         if (burst == 0) begin
            // idle for a while, then run a burst back to back
            start = 1'b0;
            repeat ($urandom_range(1, 80)) @(negedge clock);
            burst = $urandom_range(1, 12);
         end
         burst--;
         send_random_page();
      end
      start = 1'b0;

      while (board.outstanding() != 0) @(posedge clock);
      drain = DRAIN_CYCLES;
      repeat (drain) @(posedge clock);
      if (board.faults == 0 && board.outstanding() == 0) begin
         $display("PASS per_index_page_statistics");
      end else begin
         $display("FAIL per_index_page_statistics");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("FAIL per_index_page_statistics");
      $finish;
   end

endmodule

`default_nettype wire
